>>> design/srt_pkg.sv
package srt_pkg;

  localparam int unsigned THR_W   = 8;
  localparam int unsigned STEP_W  = 3;
  localparam int unsigned POLL_W  = 8;
  localparam int unsigned TEMP_W  = 29;

  localparam logic [THR_W-1:0]  START_THRESHOLD = 8'd64;
  localparam logic [STEP_W-1:0] FIRST_STEP      = 3'd4;
  localparam logic [POLL_W-1:0] POLL_RESET      = 8'd100;
  localparam logic [THR_W-1:0]  FINAL_ADJUST    = 8'd2;

  localparam logic [TEMP_W-1:0] UK_PER_DEGREE = 29'd1000000;
  localparam logic [TEMP_W-1:0] UK_AT_ZERO_C  = 29'd273150000;

  // func codes
  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_PROGRAM = 3'd1,
    ST_WAIT    = 3'd2,
    ST_DONE    = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

endpackage

>>> design/srt_channels.sv
interface srt_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] sensor_index;
  logic       cmp_valid;
  logic       cmp_above;

  modport source (output valid, func, sensor_index, cmp_valid, cmp_above, input ready);
  modport sink   (input valid, func, sensor_index, cmp_valid, cmp_above, output ready);
endinterface

interface srt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [6:0]  threshold_out;
  logic [28:0] temp_microkelvin;

  modport source (output valid, status, threshold_out, temp_microkelvin, input ready);
  modport sink   (input valid, status, threshold_out, temp_microkelvin, output ready);
endinterface

interface srt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] poll_limit;

  modport source (output valid, poll_limit, input ready);
  modport sink   (input valid, poll_limit, output ready);
endinterface

>>> design/sar_thermal_sensor_readout.sv
// Each accepted input beat's result is registered and offered as a result beat in the next cycle.
// Throughput: one item per cycle; the single output register is the only
// buffer, so input stalls only while a result waits and the sink is not ready.
// Reset (rst_n low, synchronous): no result pending, measurement idle,
// trial threshold 64, step 4, poll count 0, poll_limit 100.
module sar_thermal_sensor_readout (
  input  logic             clk,
  input  logic             rst_n,
  srt_in_if.sink           in_bus,
  srt_out_if.source        out_bus,
  srt_cfg_if.sink          cfg_bus
);

  // Measurement state
  logic                            busy_r, busy_nxt;
  logic [srt_pkg::THR_W-1:0]       trial_r, trial_nxt;
  logic [srt_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [srt_pkg::POLL_W-1:0]      poll_r, poll_nxt;
  logic [srt_pkg::POLL_W-1:0]      poll_limit_r;

  // Result register
  logic                            out_valid_r;
  srt_pkg::status_t                status_r, status_nxt;
  logic [6:0]                      thr_out_r, thr_out_nxt;
  logic [srt_pkg::TEMP_W-1:0]      temp_r, temp_nxt;

  logic                            in_accept;
  logic [srt_pkg::THR_W-1:0]       delta;
  logic [srt_pkg::THR_W-1:0]       adj_thr;
  logic [srt_pkg::THR_W-1:0]       fin_thr;
  logic                            keep_polling;

  // Accept whenever the result slot is free or is being drained this cycle.
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_accept    = in_bus.valid && in_bus.ready;

  // Config must be written only while idle; the block does not enforce this and is always ready.
  assign cfg_bus.ready = 1'b1;

  // Step size 2<<step; successive approximation move on the comparator answer.
  assign delta   = srt_pkg::THR_W'(2) << step_r;
  assign adj_thr = in_bus.cmp_above ? (trial_r + delta) : (trial_r - delta);
  assign fin_thr = adj_thr + srt_pkg::FINAL_ADJUST;

  // No valid yet and the poll budget is not exhausted (9-bit compare, no wrap).
  assign keep_polling = !in_bus.cmp_valid &&
                        (({1'b0, poll_r} + 9'd1) < {1'b0, poll_limit_r});

  always_comb begin
    busy_nxt    = busy_r;
    trial_nxt   = trial_r;
    step_nxt    = step_r;
    poll_nxt    = poll_r;
    status_nxt  = srt_pkg::ST_IDLE;
    thr_out_nxt = '0;
    temp_nxt    = '0;

    if (in_accept) begin
      if (in_bus.func == srt_pkg::FUNC_START) begin
        if (in_bus.sensor_index != 8'd0) begin
          // Unknown sensor: drop any running measurement.
          busy_nxt   = 1'b0;
          status_nxt = srt_pkg::ST_INVALID;
        end else begin
          // (Re)start from the midpoint.
          busy_nxt    = 1'b1;
          trial_nxt   = srt_pkg::START_THRESHOLD;
          step_nxt    = srt_pkg::FIRST_STEP;
          poll_nxt    = '0;
          status_nxt  = srt_pkg::ST_PROGRAM;
          thr_out_nxt = srt_pkg::START_THRESHOLD[6:0];
        end
      end else if (!busy_r) begin
        status_nxt = srt_pkg::ST_IDLE;
      end else if (keep_polling) begin
        poll_nxt   = poll_r + 8'd1;
        status_nxt = srt_pkg::ST_WAIT;
      end else begin
        poll_nxt = '0;
        if (step_r == '0) begin
          // Last step: bias by 2 and convert to microkelvin.
          trial_nxt  = fin_thr;
          busy_nxt   = 1'b0;
          step_nxt   = srt_pkg::FIRST_STEP;
          status_nxt = srt_pkg::ST_DONE;
          temp_nxt   = srt_pkg::TEMP_W'(fin_thr) * srt_pkg::UK_PER_DEGREE
                       + srt_pkg::UK_AT_ZERO_C;
        end else begin
          trial_nxt   = adj_thr;
          step_nxt    = step_r - 3'd1;
          status_nxt  = srt_pkg::ST_PROGRAM;
          thr_out_nxt = adj_thr[6:0];
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      trial_r      <= srt_pkg::START_THRESHOLD;
      step_r       <= srt_pkg::FIRST_STEP;
      poll_r       <= '0;
      poll_limit_r <= srt_pkg::POLL_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      trial_r <= trial_nxt;
      step_r  <= step_nxt;
      poll_r  <= poll_nxt;
      if (cfg_bus.valid && cfg_bus.ready) begin
        poll_limit_r <= cfg_bus.poll_limit;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted beat
  always_ff @(posedge clk) begin
    if (in_accept) begin
      status_r  <= status_nxt;
      thr_out_r <= thr_out_nxt;
      temp_r    <= temp_nxt;
    end
  end

  assign out_bus.valid            = out_valid_r;
  assign out_bus.status           = status_r;
  assign out_bus.threshold_out    = thr_out_r;
  assign out_bus.temp_microkelvin = temp_r;

endmodule
